@@ rtl/core/blk2_pkg.sv @@
// ----------------------------------------------------------------------------
// blk2_pkg
// Shared types, constants and lookup functions of the BLAKE2 compression core.
// ----------------------------------------------------------------------------
package blk2_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_LOAD,
		ST_MIX,
		ST_STORE,
		ST_FOLD,
		ST_EMIT
	} blk2_state_t;

	typedef enum logic [1:0] {
		CFG_VARIANT = 2'd0,
		CFG_DIGEST  = 2'd1,
		CFG_KEY     = 2'd2
	} blk2_cfg_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_WORD  = 1'b1;

	localparam logic [31:0] PARAM_BASE = 32'h0101_0000;
	localparam logic [6:0]  CAP_S      = 7'd32;
	localparam logic [6:0]  CAP_B      = 7'd64;
	localparam logic [3:0]  LAST_RND_S = 4'd9;
	localparam logic [3:0]  LAST_RND_B = 4'd11;
	localparam logic [3:0]  SIGMA_ROWS = 4'd10;

	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [3:0] SIGMA [10][16] = '{
		'{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15 },
		'{ 14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3 },
		'{ 11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4 },
		'{ 7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8 },
		'{ 9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13 },
		'{ 2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9 },
		'{ 12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11 },
		'{ 13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10 },
		'{ 6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5 },
		'{ 10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0 }
	};

	// word positions {a, b, c, d} of each of the eight mixes of a round
	localparam logic [15:0] MIX_IDX [8] = '{
		16'h048C, 16'h159D, 16'h26AE, 16'h37BF,
		16'h05AF, 16'h16BC, 16'h278D, 16'h349E
	};

	// IV word for the selected word size
	function automatic logic [63:0] iv_word(input logic [2:0] idx, input logic wide);
		logic [63:0] w;
		w = IV[idx];
		return wide ? w : {32'd0, w[63:32]};
	endfunction

	function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] idx);
		return SIGMA[row][idx];
	endfunction

endpackage

@@ rtl/core/blk2_mix_unit.sv @@
// ----------------------------------------------------------------------------
// blk2_mix_unit
// One quarter of the mixing function: x' = x + y + m, z' = rotr(z ^ x', n).
// ----------------------------------------------------------------------------
module blk2_mix_unit (
	input  logic [63:0] x,
	input  logic [63:0] y,
	input  logic [63:0] m,
	input  logic [63:0] z,
	input  logic        wide,
	input  logic [1:0]  rsel,
	output logic [63:0] x_new,
	output logic [63:0] z_new
);
	import blk2_pkg::*;

	logic [63:0] sum64;
	logic [63:0] t64;
	logic [31:0] sum32;
	logic [31:0] t32;

	function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [1:0] s);
		logic [63:0] r;
		case (s)
			2'd0: r = {v[31:0], v[63:32]};
			2'd1: r = {v[23:0], v[63:24]};
			2'd2: r = {v[15:0], v[63:16]};
			default: r = {v[62:0], v[63]};
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [1:0] s);
		logic [31:0] r;
		case (s)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[11:0], v[31:12]};
			2'd2: r = {v[7:0], v[31:8]};
			default: r = {v[6:0], v[31:7]};
		endcase
		return r;
	endfunction

	always_comb begin
		sum64 = x + y + m;
		sum32 = x[31:0] + y[31:0] + m[31:0];
		t64   = z ^ sum64;
		t32   = z[31:0] ^ sum32;
		x_new = wide ? sum64 : {32'd0, sum32};
		z_new = wide ? rotr64(t64, rsel) : {32'd0, rotr32(t32, rsel)};
	end

endmodule

@@ rtl/core/blake2_compression_unit.sv @@
// ----------------------------------------------------------------------------
// blake2_compression_unit
// BLAKE2b / BLAKE2s compression core with message block and chain storage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): op = start loads the chain from the
//   IV and the parameter word (digest and key length); op = word writes the
//   next of sixteen block words. The sixteenth beat also carries byte_count
//   and final_block and launches the compression.
//   Output channel (out_valid / out_stall): after a final block eight beats
//   give chain words 0..7, last marks word 7.
//   Config channel (cfg_valid / cfg_ready): variant, digest_bytes, key_bytes;
//   always ready, write only while the core is idle.
// Sequence:
//   Start and non-closing word beats are taken while the core is idle. A
//   compression runs the mix unit four times per mix, with a load before
//   and a write back after each mix, after one setup step and before one
//   fold step. in_stall is high the whole time.
// Reset: control state clears, registers take BLAKE2b / 64 / 0. Chain and
//   block contents are undefined until written.
// Stall: a stalled output beat holds; the core waits without losing words.
// ----------------------------------------------------------------------------
module blake2_compression_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] message_word,
	input  logic [63:0] byte_count,
	input  logic        final_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	import blk2_pkg::*;

	blk2_state_t state_q, state_d;

	logic        variant_q;
	logic [6:0]  digest_q;
	logic [6:0]  key_q;

	logic [63:0] chain_q [8];
	logic [63:0] blk_q [16];
	logic [63:0] v_q [16];
	logic [63:0] a_q, b_q, c_q, d_q;
	logic [63:0] cnt_q;
	logic        fin_q;
	logic [3:0]  wcnt_q;
	logic [3:0]  rnd_q;
	logic [2:0]  g_q;
	logic [1:0]  qtr_q;
	logic [2:0]  oidx_q;

	logic        in_acc;
	logic        out_acc;
	logic [63:0] mask;
	logic [6:0]  cap, dl, kl;
	logic [3:0]  last_rnd;
	logic [3:0]  row;
	logic [3:0]  ia, ib, ic, id;
	logic [63:0] mword;
	logic [63:0] ux, uy, um, uz, ux_new, uz_new;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	assign mask     = variant_q ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
	assign cap      = variant_q ? CAP_B : CAP_S;
	assign dl       = (digest_q > cap) ? cap : digest_q;
	assign kl       = (key_q > cap) ? cap : key_q;
	assign last_rnd = variant_q ? LAST_RND_B : LAST_RND_S;
	assign row      = (rnd_q >= SIGMA_ROWS) ? rnd_q - SIGMA_ROWS : rnd_q;
	assign {ia, ib, ic, id} = MIX_IDX[g_q];

	// message word for the first or second add of the current mix
	assign mword = blk_q[sigma(row, {g_q, qtr_q[1]})] & mask;

	// even quarters update a and d, odd quarters c and b
	always_comb begin
		if (!qtr_q[0]) begin
			ux = a_q;
			uy = b_q;
			uz = d_q;
			um = mword;
		end else begin
			ux = c_q;
			uy = d_q;
			uz = b_q;
			um = 64'd0;
		end
	end

	blk2_mix_unit u_mix (
		.x     (ux),
		.y     (uy),
		.m     (um),
		.z     (uz),
		.wide  (variant_q),
		.rsel  (qtr_q),
		.x_new (ux_new),
		.z_new (uz_new)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_WORD && wcnt_q == 4'd15)
					state_d = ST_INIT;
			end
			ST_INIT:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_MIX;
			ST_MIX: begin
				if (qtr_q == 2'd3)
					state_d = ST_STORE;
			end
			ST_STORE: begin
				if (g_q == 3'd7 && rnd_q == last_rnd)
					state_d = ST_FOLD;
				else
					state_d = ST_LOAD;
			end
			ST_FOLD:  state_d = fin_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (out_acc && oidx_q == 3'd7)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_EMIT);
	end

	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;
	assign last        = (oidx_q == 3'd7);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			variant_q <= 1'b1;
			digest_q  <= 7'd64;
			key_q     <= 7'd0;
			wcnt_q    <= 4'd0;
			rnd_q     <= 4'd0;
			g_q       <= 3'd0;
			qtr_q     <= 2'd0;
			oidx_q    <= 3'd0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VARIANT: variant_q <= cfg_data[0];
					CFG_DIGEST:  digest_q  <= cfg_data;
					CFG_KEY:     key_q     <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				// start drops any partial block
				if (op == OP_START)
					wcnt_q <= 4'd0;
				else
					wcnt_q <= wcnt_q + 4'd1;
			end
			if (state_q == ST_MIX)
				qtr_q <= qtr_q + 2'd1;
			if (state_q == ST_STORE) begin
				g_q <= g_q + 3'd1;
				if (g_q == 3'd7)
					rnd_q <= (rnd_q == last_rnd) ? 4'd0 : rnd_q + 4'd1;
			end
			if (state_q == ST_FOLD)
				oidx_q <= 3'd0;
			else if (out_acc)
				oidx_q <= oidx_q + 3'd1;
		end
	end

	// datapath storage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (op == OP_START) begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= iv_word(3'(i), variant_q);
				chain_q[0] <= iv_word(3'd0, variant_q)
					^ {32'd0, PARAM_BASE | {17'd0, kl, 8'd0} | {25'd0, dl}};
			end else begin
				blk_q[wcnt_q] <= message_word & mask;
				cnt_q         <= byte_count;
				fin_q         <= final_block;
			end
		end
		unique case (state_q)
			ST_INIT: begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i]  <= chain_q[i] & mask;
					v_q[i]      <= chain_q[i] & mask;
					v_q[i + 8]  <= iv_word(3'(i), variant_q);
				end
				v_q[12] <= iv_word(3'd4, variant_q) ^ (cnt_q & mask);
				v_q[13] <= iv_word(3'd5, variant_q) ^ (variant_q ? 64'd0 : {32'd0, cnt_q[63:32]});
				if (fin_q)
					v_q[14] <= ~iv_word(3'd6, variant_q) & mask;
			end
			ST_LOAD: begin
				a_q <= v_q[ia];
				b_q <= v_q[ib];
				c_q <= v_q[ic];
				d_q <= v_q[id];
			end
			ST_MIX: begin
				if (!qtr_q[0]) begin
					a_q <= ux_new;
					d_q <= uz_new;
				end else begin
					c_q <= ux_new;
					b_q <= uz_new;
				end
			end
			ST_STORE: begin
				v_q[ia] <= a_q;
				v_q[ib] <= b_q;
				v_q[ic] <= c_q;
				v_q[id] <= d_q;
			end
			ST_FOLD: begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i + 8];
			end
			default: ;
		endcase
	end

endmodule

@@ dv/blake2_compression_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blake2_compression_unit_tb
// Self-checking bench for the BLAKE2b / BLAKE2s compression core. Drives
// message beats with random gaps and output stalls, recomputes every chain
// word in a local BLAKE2 model and checks each digest beat in order.
// ----------------------------------------------------------------------------
module blake2_compression_unit_tb;
	import blk2_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	// settle time, past the longest compression
	localparam int SETTLE      = 700;

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [63:0] message_word;
	logic [63:0] byte_count;
	logic        final_block;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	blake2_compression_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .message_word(message_word),
		.byte_count(byte_count), .final_block(final_block),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last(last)
	);

	// local copy of the core's registers and storage
	logic        mdl_wide;
	logic [6:0]  mdl_digest_len;
	logic [6:0]  mdl_key_len;
	logic [63:0] mdl_chain [8];
	logic [63:0] mdl_block [16];
	logic [63:0] mdl_work [16];
	logic [3:0]  mdl_fill;

	digest_beat_t pending_digest [$];
	int           errors;
	int           cycles;
	bit           idle_on;
	bit           hold_req;
	int           hold_left;
	int           stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n, input logic wide);
		logic [31:0] h;
		h = x[31:0];
		if (wide)
			return (x >> n) | (x << (64 - n));
		return {32'd0, (h >> n) | (h << (32 - n))};
	endfunction

	function automatic void mix_words(input int rnd, input int g);
		logic [63:0] mask, va, vb, vc, vd, x, y;
		int a, b, c, d;
		int r0, r1, r2, r3;
		mask = mdl_wide ? '1 : 64'h0000_0000_FFFF_FFFF;
		a = int'(MIX_IDX[g][15:12]);
		b = int'(MIX_IDX[g][11:8]);
		c = int'(MIX_IDX[g][7:4]);
		d = int'(MIX_IDX[g][3:0]);
		if (mdl_wide) begin
			r0 = 32; r1 = 24; r2 = 16; r3 = 63;
		end else begin
			r0 = 16; r1 = 12; r2 = 8; r3 = 7;
		end
		va = mdl_work[a]; vb = mdl_work[b]; vc = mdl_work[c]; vd = mdl_work[d];
		x = mdl_block[SIGMA[rnd % 10][2 * g]] & mask;
		y = mdl_block[SIGMA[rnd % 10][2 * g + 1]] & mask;
		va = (va + vb + x) & mask;
		vd = rotr(vd ^ va, r0, mdl_wide);
		vc = (vc + vd) & mask;
		vb = rotr(vb ^ vc, r1, mdl_wide);
		va = (va + vb + y) & mask;
		vd = rotr(vd ^ va, r2, mdl_wide);
		vc = (vc + vd) & mask;
		vb = rotr(vb ^ vc, r3, mdl_wide);
		mdl_work[a] = va; mdl_work[b] = vb; mdl_work[c] = vc; mdl_work[d] = vd;
	endfunction

	function automatic void compress_block(input logic [63:0] cnt, input logic fin);
		logic [63:0] mask;
		int rounds;
		mask = mdl_wide ? '1 : 64'h0000_0000_FFFF_FFFF;
		rounds = mdl_wide ? 12 : 10;
		for (int i = 0; i < 8; i++) begin
			mdl_chain[i] &= mask;
			mdl_work[i] = mdl_chain[i];
			mdl_work[8 + i] = mdl_wide ? IV[i] : (IV[i] >> 32);
		end
		mdl_work[12] ^= cnt & mask;
		if (!mdl_wide)
			mdl_work[13] ^= cnt >> 32;
		if (fin)
			mdl_work[14] = ~mdl_work[14] & mask;
		for (int r = 0; r < rounds; r++)
			for (int g = 0; g < 8; g++)
				mix_words(r, g);
		for (int i = 0; i < 8; i++)
			mdl_chain[i] ^= mdl_work[i] ^ mdl_work[8 + i];
	endfunction

	// advance the local model by one accepted input beat
	function automatic void predict_digest(input logic o, input logic [63:0] w,
			input logic [63:0] cnt, input logic fin);
		logic [63:0] mask;
		logic [6:0]  cap, dl, kl;
		digest_beat_t e;
		mask = mdl_wide ? '1 : 64'h0000_0000_FFFF_FFFF;
		if (o == OP_START) begin
			cap = mdl_wide ? CAP_B : CAP_S;
			dl = (mdl_digest_len > cap) ? cap : mdl_digest_len;
			kl = (mdl_key_len > cap) ? cap : mdl_key_len;
			for (int i = 0; i < 8; i++)
				mdl_chain[i] = mdl_wide ? IV[i] : (IV[i] >> 32);
			mdl_chain[0] ^= {32'd0, PARAM_BASE} | (64'(kl) << 8) | 64'(dl);
			mdl_fill = 4'd0;
			return;
		end
		mdl_block[mdl_fill] = w & mask;
		if (mdl_fill != 4'd15) begin
			mdl_fill = mdl_fill + 4'd1;
			return;
		end
		mdl_fill = 4'd0;
		compress_block(cnt, fin);
		if (!fin)
			return;
		for (int i = 0; i < 8; i++) begin
			e.word = mdl_chain[i] & mask;
			e.index = 3'(i);
			e.last = (i == 7);
			pending_digest.push_back(e);
		end
	endfunction

	// output side: check each beat, then draw the stall before the next one
	always @(posedge clk) begin
		digest_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_digest.size() == 0) begin
				$display("%0t: unexpected digest beat word %h index %0d", $time,
					digest_word, word_index);
				errors++;
			end else begin
				e = pending_digest.pop_front();
				if (digest_word !== e.word) begin
					$display("%0t: digest_word expected %h actual %h", $time, e.word,
						digest_word);
					errors++;
				end
				if (word_index !== e.index) begin
					$display("%0t: word_index expected %0d actual %0d", $time, e.index,
						word_index);
					errors++;
				end
				if (last !== e.last) begin
					$display("%0t: last expected %0d actual %0d", $time, e.last, last);
					errors++;
				end
			end
			stall_left = idle_on ? $urandom_range(0, 12) : 0;
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 2500;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// offer one beat after a random gap, hold it until accepted
	task automatic send_beat(input logic o, input logic [63:0] w,
			input logic [63:0] cnt, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		message_word <= w;
		byte_count   <= cnt;
		final_block  <= fin;
		do @(posedge clk); while (in_stall);
		predict_digest(o, w, cnt, fin);
	endtask

	// drop valid, wait for every digest beat, then let a silent compression end
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_digest.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input blk2_cfg_t idx, input logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_VARIANT: mdl_wide = data[0];
			CFG_DIGEST:  mdl_digest_len = data;
			default:     mdl_key_len = data;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic wide, input logic [6:0] dl, input logic [6:0] kl);
		write_reg(CFG_VARIANT, {6'd0, wide});
		write_reg(CFG_DIGEST, dl);
		write_reg(CFG_KEY, kl);
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(input logic [63:0] cnt, input logic fin);
		for (int i = 0; i < 15; i++)
			send_beat(OP_WORD, pick_word(), {$urandom, $urandom}, ~fin);
		send_beat(OP_WORD, pick_word(), cnt, fin);
	endtask

	// reset values (BLAKE2b, 64, 0); extreme words, full byte count, and a
	// start that drops a partly filled block
	task automatic test_defaults();
		send_beat(OP_START, '1, '1, 1'b1);
		send_beat(OP_WORD, '1, '0, 1'b1);
		send_beat(OP_WORD, '0, '0, 1'b1);
		send_beat(OP_START, '0, '0, 1'b0);
		for (int i = 0; i < 15; i++)
			send_beat(OP_WORD, (i % 2) ? '1 : 64'h8000_0000_0000_0001, '0, 1'b0);
		send_beat(OP_WORD, '1, '1, 1'b1);
		drain();
	endtask

	// length saturation in both variants, zero digest length
	task automatic test_lengths();
		set_mode(1'b0, 7'd127, 7'd127);
		send_beat(OP_START, '0, '0, 1'b0);
		send_block(64'hFFFF_FFFF_0000_0040, 1'b1);
		drain();
		set_mode(1'b1, 7'd0, 7'd65);
		send_beat(OP_START, '0, '0, 1'b0);
		send_block('0, 1'b1);
		drain();
	endtask

	// blocks after a final one keep folding onto the same chain
	task automatic test_after_final();
		set_mode(1'b0, 7'd32, 7'd0);
		send_beat(OP_START, '0, '0, 1'b0);
		send_block(64'd64, 1'b1);
		send_block(64'd128, 1'b1);
		drain();
	endtask

	// switch word size between the blocks of one message
	task automatic test_variant_switch();
		set_mode(1'b1, 7'd64, 7'd32);
		send_beat(OP_START, '0, '0, 1'b0);
		send_block(64'd128, 1'b0);
		drain();
		write_reg(CFG_VARIANT, 7'd0);
		send_block(64'd200, 1'b1);
		drain();
		write_reg(CFG_VARIANT, 7'd1);
		send_beat(OP_START, '0, '0, 1'b0);
		send_block(64'd64, 1'b0);
		drain();
	endtask

	// hold the output for a long stretch while two messages are offered
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int m = 0; m < 2; m++) begin
			send_beat(OP_START, '0, '0, 1'b0);
			send_block({$urandom, $urandom}, 1'b1);
		end
		drain();
	endtask

	task automatic test_random();
		int nblk;
		for (int ph = 0; ph < 6; ph++) begin
			idle_on = (ph % 4) != 3;
			set_mode(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)));
			send_beat(OP_START, pick_word(), pick_word(), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0) begin
				// broken block, dropped by a fresh start
				repeat ($urandom_range(1, 15))
					send_beat(OP_WORD, pick_word(), pick_word(),
						1'($urandom_range(0, 1)));
				send_beat(OP_START, pick_word(), pick_word(), 1'b0);
			end
			nblk = $urandom_range(1, 2);
			for (int b = 0; b < nblk; b++)
				send_block(pick_word(), b == nblk - 1);
			if ($urandom_range(0, 9) == 0)
				send_block(pick_word(), 1'b1);
			drain();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_VARIANT;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_START;
		message_word = '0;
		byte_count = '0;
		final_block = 1'b0;
		out_stall = 1'b0;
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		mdl_wide = 1'b1;
		mdl_digest_len = 7'd64;
		mdl_key_len = 7'd0;
		mdl_fill = 4'd0;
		for (int i = 0; i < 8; i++)
			mdl_chain[i] = '0;
		for (int i = 0; i < 16; i++)
			mdl_block[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_lengths();
		test_after_final();
		test_variant_switch();
		test_backpressure();
		test_random();

		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/blk2_pkg.sv
rtl/core/blk2_mix_unit.sv
rtl/core/blake2_compression_unit.sv
dv/blake2_compression_unit_tb.sv
